### rtl/tto_pkg.sv
package tto_pkg;

  localparam int COORD_WIDTH_DEF = 17;

  localparam int C_LT = 0;
  localparam int C_LB = 1;
  localparam int C_RT = 2;
  localparam int C_RB = 3;

  localparam int B_TOP    = 0;
  localparam int B_BOTTOM = 1;
  localparam int B_LEFT   = 2;
  localparam int B_RIGHT  = 3;

  typedef struct packed {
    logic       p_pos;
    logic       p_neg;
    logic [3:0] c_pos;
    logic [3:0] c_neg;
    logic [3:0] up;
    logic [3:0] dn;
  } edge_res_t;

  function automatic logic edge_cross(edge_res_t e);
    logic t_hit, b_hit, l_hit, r_hit;
    t_hit = (e.up[B_TOP] && e.c_pos[C_LT] && e.c_neg[C_RT]) ||
            (e.dn[B_TOP] && e.c_neg[C_LT] && e.c_pos[C_RT]);
    b_hit = (e.up[B_BOTTOM] && e.c_pos[C_LB] && e.c_neg[C_RB]) ||
            (e.dn[B_BOTTOM] && e.c_neg[C_LB] && e.c_pos[C_RB]);
    l_hit = (e.up[B_LEFT] && e.c_neg[C_LT] && e.c_pos[C_LB]) ||
            (e.dn[B_LEFT] && e.c_pos[C_LT] && e.c_neg[C_LB]);
    r_hit = (e.up[B_RIGHT] && e.c_neg[C_RT] && e.c_pos[C_RB]) ||
            (e.dn[B_RIGHT] && e.c_pos[C_RT] && e.c_neg[C_RB]);
    return t_hit || b_hit || l_hit || r_hit;
  endfunction

  function automatic logic [3:0] edge_inner(edge_res_t e);
    return ({4{e.p_pos}} & e.c_pos) | ({4{e.p_neg}} & e.c_neg);
  endfunction

endpackage

### rtl/triangle_tile_overlap_test.sv
// Channel | Handshake                  | Payload
// item    | item_valid / item_stall    | vert0_x .. vert2_y, tile_left .. tile_bottom
// result  | result_valid / result_stall| overlaps
//
// Four register stages: edge differences, products, product-difference signs, and the
// final combine into the result register. One item per cycle while the pipeline is not stalled.
// The whole pipeline advances unless a valid result is stalled; item_stall follows that.
// Reset (rst, synchronous) clears the valid bits only.
module triangle_tile_overlap_test #(
  parameter int COORD_WIDTH = tto_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic signed [COORD_WIDTH-1:0] vert0_x,
  input  logic signed [COORD_WIDTH-1:0] vert0_y,
  input  logic signed [COORD_WIDTH-1:0] vert1_x,
  input  logic signed [COORD_WIDTH-1:0] vert1_y,
  input  logic signed [COORD_WIDTH-1:0] vert2_x,
  input  logic signed [COORD_WIDTH-1:0] vert2_y,
  input  logic signed [COORD_WIDTH-1:0] tile_left,
  input  logic signed [COORD_WIDTH-1:0] tile_right,
  input  logic signed [COORD_WIDTH-1:0] tile_top,
  input  logic signed [COORD_WIDTH-1:0] tile_bottom,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          overlaps
);

  logic adv;
  logic v1, v2, v3;
  logic vh1, vh2, vh3;
  logic vh_next;
  tto_pkg::edge_res_t e0, e1, e2;
  logic [3:0] corner_in;
  logic cross_hit;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  tto_edge #(.CW(COORD_WIDTH)) u_edge0 (
    .clk(clk), .en(adv),
    .xa(vert0_x), .ya(vert0_y), .xb(vert1_x), .yb(vert1_y), .xp(vert2_x), .yp(vert2_y),
    .l(tile_left), .r(tile_right), .t(tile_top), .b(tile_bottom), .res(e0)
  );

  tto_edge #(.CW(COORD_WIDTH)) u_edge1 (
    .clk(clk), .en(adv),
    .xa(vert1_x), .ya(vert1_y), .xb(vert2_x), .yb(vert2_y), .xp(vert0_x), .yp(vert0_y),
    .l(tile_left), .r(tile_right), .t(tile_top), .b(tile_bottom), .res(e1)
  );

  tto_edge #(.CW(COORD_WIDTH)) u_edge2 (
    .clk(clk), .en(adv),
    .xa(vert2_x), .ya(vert2_y), .xb(vert0_x), .yb(vert0_y), .xp(vert1_x), .yp(vert1_y),
    .l(tile_left), .r(tile_right), .t(tile_top), .b(tile_bottom), .res(e2)
  );

  assign vh_next =
    (vert0_x > tile_left && vert0_x < tile_right && vert0_y > tile_top && vert0_y < tile_bottom) ||
    (vert1_x > tile_left && vert1_x < tile_right && vert1_y > tile_top && vert1_y < tile_bottom) ||
    (vert2_x > tile_left && vert2_x < tile_right && vert2_y > tile_top && vert2_y < tile_bottom);

  assign corner_in = tto_pkg::edge_inner(e0) & tto_pkg::edge_inner(e1) &
                     tto_pkg::edge_inner(e2);
  assign cross_hit = tto_pkg::edge_cross(e0) || tto_pkg::edge_cross(e1) ||
                     tto_pkg::edge_cross(e2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= item_valid;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vh1      <= vh_next;
      vh2      <= vh1;
      vh3      <= vh2;
      overlaps <= vh3 || (|corner_in) || cross_hit;
    end
  end

endmodule

### rtl/tto_edge.sv
module tto_edge #(
  parameter int CW = tto_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] xa,
  input  logic signed [CW-1:0] ya,
  input  logic signed [CW-1:0] xb,
  input  logic signed [CW-1:0] yb,
  input  logic signed [CW-1:0] xp,
  input  logic signed [CW-1:0] yp,
  input  logic signed [CW-1:0] l,
  input  logic signed [CW-1:0] r,
  input  logic signed [CW-1:0] t,
  input  logic signed [CW-1:0] b,
  output tto_pkg::edge_res_t   res
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dx, dy, dxp, dyp, dxl, dxr, dyt, dyb;
  logic [3:0] up1, dn1, up2, dn2;
  logic signed [PW-1:0] pp_x, pp_y, a_l, a_r, b_t, b_b;
  logic signed [PW:0] s_p, s_lt, s_lb, s_rt, s_rb;

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= DW'(xb) - DW'(xa);
      dy  <= DW'(yb) - DW'(ya);
      dxp <= DW'(xp) - DW'(xa);
      dyp <= DW'(yp) - DW'(ya);
      dxl <= DW'(xa) - DW'(l);
      dxr <= DW'(xa) - DW'(r);
      dyt <= DW'(ya) - DW'(t);
      dyb <= DW'(ya) - DW'(b);
      up1 <= {xa < r && xb > r, xa < l && xb > l, ya < b && yb > b, ya < t && yb > t};
      dn1 <= {xa > r && xb < r, xa > l && xb < l, ya > b && yb < b, ya > t && yb < t};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_x <= dx * dyp;
      pp_y <= dy * dxp;
      a_l  <= dy * dxl;
      a_r  <= dy * dxr;
      b_t  <= dx * dyt;
      b_b  <= dx * dyb;
      up2  <= up1;
      dn2  <= dn1;
    end
  end

  assign s_p  = (PW+1)'(pp_x) - (PW+1)'(pp_y);
  assign s_lt = (PW+1)'(a_l) - (PW+1)'(b_t);
  assign s_lb = (PW+1)'(a_l) - (PW+1)'(b_b);
  assign s_rt = (PW+1)'(a_r) - (PW+1)'(b_t);
  assign s_rb = (PW+1)'(a_r) - (PW+1)'(b_b);

  always_ff @(posedge clk) begin
    if (en) begin
      res.p_pos <= !s_p[PW] && (|s_p);
      res.p_neg <= s_p[PW];
      res.c_pos[tto_pkg::C_LT] <= !s_lt[PW] && (|s_lt);
      res.c_pos[tto_pkg::C_LB] <= !s_lb[PW] && (|s_lb);
      res.c_pos[tto_pkg::C_RT] <= !s_rt[PW] && (|s_rt);
      res.c_pos[tto_pkg::C_RB] <= !s_rb[PW] && (|s_rb);
      res.c_neg[tto_pkg::C_LT] <= s_lt[PW];
      res.c_neg[tto_pkg::C_LB] <= s_lb[PW];
      res.c_neg[tto_pkg::C_RT] <= s_rt[PW];
      res.c_neg[tto_pkg::C_RB] <= s_rb[PW];
      res.up <= up2;
      res.dn <= dn2;
    end
  end

endmodule
